FILE: hdl/delta_vertex_bitstream_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
// Each module that includes this header must provide i_clk and i_rst_n.
`ifndef DELTA_VERTEX_BITSTREAM_DECODER_ASSERT_SVH
`define DELTA_VERTEX_BITSTREAM_DECODER_ASSERT_SVH

// Checked only while out of reset.
`define DVBD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dvbd assertion failed");

// Checked at every edge, reset included.
`define DVBD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("dvbd assertion failed");

`endif

FILE: hdl/dvbd_pkg.sv
// ----------------------------------------------------------------------------
// dvbd_pkg
// Types and constants shared by the delta vertex bitstream decoder.
// ----------------------------------------------------------------------------
package dvbd_pkg;

    localparam int unsigned DEF_BUFFER_BITS = 64;
    localparam int unsigned WORD_BITS       = 32;
    localparam int unsigned CTL_BITS        = 32;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_PUSH   = 2'd1,
        OP_DECODE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                   op;
        logic [WORD_BITS-1:0]  stream_word;
        logic [CTL_BITS-1:0]   delta_control;
        logic                  skip_vertex;
    } t_cmd;

    typedef struct packed {
        logic [7:0] coord_x;
        logic [7:0] coord_z;
        logic [7:0] coord_y;
        t_status    status;
    } t_vertex;

    typedef struct packed {
        logic    valid;
        t_vertex vertex;
    } t_step;

endpackage

FILE: hdl/dvbd_cmd_if.sv
// ----------------------------------------------------------------------------
// dvbd_cmd_if
// Command channel: operation, stream word, vertex control and skip flag.
// ----------------------------------------------------------------------------
interface dvbd_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] stream_word;
    logic [31:0] delta_control;
    logic        skip_vertex;

    modport source (
        output valid, operation, stream_word, delta_control, skip_vertex,
        input  ready
    );
    modport sink (
        input  valid, operation, stream_word, delta_control, skip_vertex,
        output ready
    );
endinterface

FILE: hdl/dvbd_res_if.sv
// ----------------------------------------------------------------------------
// dvbd_res_if
// Result channel: decoded coordinate bytes and status.
// ----------------------------------------------------------------------------
interface dvbd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] coord_x;
    logic [7:0] coord_z;
    logic [7:0] coord_y;
    logic [1:0] status;

    modport source (
        output valid, coord_x, coord_z, coord_y, status,
        input  ready
    );
    modport sink (
        input  valid, coord_x, coord_z, coord_y, status,
        output ready
    );
endinterface

FILE: hdl/delta_vertex_bitstream_decoder.sv
// A command is held in the input register; when it advances, its result is registered in the result register.
// Throughput: one command per cycle unless the input stage stalls; the step logic is combinational.
// The input stage stalls only when a command that yields a result meets a full
// output register that is not being drained.
// Reset (synchronous, active low) empties the bit buffer, zeroes the accumulators
// and clears both valid flags.
// ----------------------------------------------------------------------------
// delta_vertex_bitstream_decoder
// Delta-compressed vertex decoder: input register, step logic, result register.
// ----------------------------------------------------------------------------
`include "delta_vertex_bitstream_decoder_assert.svh"

module delta_vertex_bitstream_decoder #(
    parameter int unsigned BUFFER_BITS = dvbd_pkg::DEF_BUFFER_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dvbd_cmd_if.sink   i_cmd,
    dvbd_res_if.source o_res
);
    import dvbd_pkg::*;

    logic    r_in_valid;
    t_cmd    r_cmd;
    logic    r_out_valid;
    t_vertex r_out;
    t_step   w_step;
    logic    w_adv;
    logic    w_take;
    logic    w_out_zero;

    // Commands with no result always advance; results need a free slot.
    assign w_adv  = r_in_valid && (!w_step.valid || !r_out_valid || o_res.ready);
    assign w_take = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.op            <= t_op'(i_cmd.operation);
            r_cmd.stream_word   <= i_cmd.stream_word;
            r_cmd.delta_control <= i_cmd.delta_control;
            r_cmd.skip_vertex   <= i_cmd.skip_vertex;
        end
    end

    dvbd_core #(
        .BUFFER_BITS(BUFFER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_cmd   (r_cmd),
        .o_step  (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_step.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_step.valid) begin
            r_out <= w_step.vertex;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.coord_x = r_out.coord_x;
    assign o_res.coord_z = r_out.coord_z;
    assign o_res.coord_y = r_out.coord_y;
    assign o_res.status  = r_out.status;

    assign w_out_zero = (r_out.coord_x == 8'd0) && (r_out.coord_y == 8'd0) &&
                        (r_out.coord_z == 8'd0);

    `DVBD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_out_valid && !r_in_valid)
    `DVBD_ASSERT(a_take_loads, w_take |=> r_in_valid)
    `DVBD_ASSERT(a_error_zero, r_out_valid && r_out.status != ST_OK |-> w_out_zero)

endmodule

FILE: hdl/dvbd_core.sv
// ----------------------------------------------------------------------------
// dvbd_core
// Bit buffer, axis accumulators and the combinational step logic.
// ----------------------------------------------------------------------------
`include "delta_vertex_bitstream_decoder_assert.svh"

module dvbd_core #(
    parameter int unsigned BUFFER_BITS = dvbd_pkg::DEF_BUFFER_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  dvbd_pkg::t_cmd i_cmd,
    output dvbd_pkg::t_step o_step
);
    import dvbd_pkg::*;

    localparam int unsigned HW = $clog2(BUFFER_BITS + 1);

    // Take n (1..8) bits starting at bit offset off from the top, sign-extended.
    function automatic logic [7:0] take_bits(logic [23:0] bits, logic [4:0] off,
                                             logic [3:0] n);
        logic [23:0] s;
        logic [7:0]  v;
        s = bits << off;
        v = s[23:16] >> (4'd8 - n);
        if (s[23]) begin
            v = v | (8'hFF << n);
        end
        return v;
    endfunction

    logic [BUFFER_BITS-1:0] r_buf, n_buf;
    logic [HW-1:0]          r_held, n_held;
    logic [7:0]             r_acc_x, n_acc_x;
    logic [7:0]             r_acc_y, n_acc_y;
    logic [7:0]             r_acc_z, n_acc_z;

    logic [3:0]  w_wx, w_wy, w_wz;
    logic [4:0]  w_off_z, w_total;
    logic [7:0]  w_dx, w_dy, w_dz;
    logic [7:0]  w_bx, w_by, w_bz;
    logic [7:0]  w_base_x, w_base_y, w_base_z;
    logic [7:0]  w_sum_x, w_sum_y, w_sum_z;
    logic        w_short, w_full;
    logic [23:0] w_top;
    logic [BUFFER_BITS-1:0] w_append;

    assign w_wx    = {1'b0, i_cmd.delta_control[8:6]} + 4'd1;
    assign w_wy    = {1'b0, i_cmd.delta_control[5:3]} + 4'd1;
    assign w_wz    = {1'b0, i_cmd.delta_control[2:0]} + 4'd1;
    assign w_off_z = {1'b0, w_wx} + {1'b0, w_wy};
    assign w_total = w_off_z + {1'b0, w_wz};

    assign w_top = r_buf[BUFFER_BITS-1 -: 24];
    assign w_dx  = take_bits(w_top, 5'd0, w_wx);
    assign w_dy  = take_bits(w_top, {1'b0, w_wx}, w_wy);
    assign w_dz  = take_bits(w_top, w_off_z, w_wz);

    assign w_bx = {i_cmd.delta_control[31:25], 1'b0};
    assign w_by = i_cmd.delta_control[24:17];
    assign w_bz = i_cmd.delta_control[16:9];

    // Width code 7 restarts the axis from zero.
    assign w_base_x = (w_wx == 4'd8) ? 8'd0 : r_acc_x;
    assign w_base_y = (w_wy == 4'd8) ? 8'd0 : r_acc_y;
    assign w_base_z = (w_wz == 4'd8) ? 8'd0 : r_acc_z;
    assign w_sum_x  = w_base_x + w_dx + w_bx;
    assign w_sum_y  = w_base_y + w_dy + w_by;
    assign w_sum_z  = w_base_z + w_dz + w_bz;

    assign w_short = r_held < {{(HW-5){1'b0}}, w_total};
    assign w_full  = ({1'b0, r_held} + (HW+1)'(WORD_BITS)) > (HW+1)'(BUFFER_BITS);

    // Buffer is left-aligned: the new word lands right below the held bits.
    assign w_append = {i_cmd.stream_word, {(BUFFER_BITS-WORD_BITS){1'b0}}} >> r_held;

    always_comb begin
        n_buf   = r_buf;
        n_held  = r_held;
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        n_acc_z = r_acc_z;
        o_step  = '0;
        unique case (i_cmd.op)
            OP_START: begin
                n_buf   = '0;
                n_held  = '0;
                n_acc_x = '0;
                n_acc_y = '0;
                n_acc_z = '0;
            end
            OP_PUSH: begin
                if (w_full) begin
                    o_step.valid         = 1'b1;
                    o_step.vertex.status = ST_FULL;
                end else begin
                    n_buf  = r_buf | w_append;
                    n_held = r_held + HW'(WORD_BITS);
                end
            end
            OP_DECODE: begin
                if (!i_cmd.skip_vertex) begin
                    o_step.valid = 1'b1;
                    if (w_short) begin
                        o_step.vertex.status = ST_SHORT;
                    end else begin
                        n_buf   = r_buf << w_total;
                        n_held  = r_held - {{(HW-5){1'b0}}, w_total};
                        n_acc_x = w_sum_x;
                        n_acc_y = w_sum_y;
                        n_acc_z = w_sum_z;
                        o_step.vertex.coord_x = w_sum_x;
                        o_step.vertex.coord_z = w_sum_z;
                        o_step.vertex.coord_y = w_sum_y;
                        o_step.vertex.status  = ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_held  <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (i_fire) begin
            r_buf   <= n_buf;
            r_held  <= n_held;
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_acc_z <= n_acc_z;
        end
    end

    `DVBD_ASSERT(a_held_in_range, r_held <= HW'(BUFFER_BITS))
    `DVBD_ASSERT(a_start_clears, i_fire && i_cmd.op == OP_START |=> r_held == '0 && r_acc_x == '0)
    `DVBD_ASSERT(a_short_keeps, i_fire && o_step.valid && o_step.vertex.status == ST_SHORT |=> $stable(r_held) && $stable(r_buf))

endmodule
